### hdl/vda_pkg.sv
// shared types and constants for the vector distance accumulator
package vda_pkg;

  localparam int unsigned AccW = 48;
  localparam int unsigned MaxRows = 1024;

  localparam logic [1:0] MetricEuclid    = 2'd0;
  localparam logic [1:0] MetricMaximum   = 2'd1;
  localparam logic [1:0] MetricManhattan = 2'd2;
  localparam logic [1:0] MetricCanberra  = 2'd3;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last;
  } vda_in_t;

  typedef struct packed {
    logic [AccW-1:0] distance;
    logic            saturated;
  } vda_out_t;

  // request to the shared shift-subtract unit
  typedef struct packed {
    logic            start;
    logic            sqrt_mode;
    logic [AccW-1:0] num;
    logic [16:0]     den;
  } vda_ss_req_t;

  typedef struct packed {
    logic            done;
    logic [AccW-1:0] result;
  } vda_ss_rsp_t;

endpackage

### hdl/vda_shift_sub.sv
// shared iterative shift-subtract unit: radix-2 divider and integer square root
module vda_shift_sub
  import vda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vda_ss_req_t req_i,
  output vda_ss_rsp_t rsp_o
);

  localparam logic [4:0] DivSteps  = 5'd24;
  localparam logic [4:0] SqrtSteps = 5'd24;

  logic            busy_q, busy_d;
  logic            mode_q, mode_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [AccW-1:0] rem_q, rem_d;
  logic [AccW-1:0] quo_q, quo_d;
  logic [AccW-1:0] num_q, num_d;
  logic [16:0]     den_q, den_d;
  logic            done_q, done_d;

  logic [AccW:0]   trial;
  logic [AccW-1:0] rem_sh;

  // one quotient bit or one root bit per cycle
  // divide yields (num << 16) / den for num <= den: the high bits of the
  // shifted numerator are preloaded into the remainder, the low 24 are stepped
  always_comb begin
    busy_d = busy_q;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    den_d  = den_q;
    done_d = 1'b0;
    rem_sh = '0;
    trial  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.sqrt_mode;
      cnt_d  = req_i.sqrt_mode ? SqrtSteps : DivSteps;
      rem_d  = req_i.sqrt_mode ? '0 : (req_i.num >> 8);
      quo_d  = '0;
      num_d  = req_i.sqrt_mode ? req_i.num : (req_i.num << (AccW - 8));
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (mode_q) begin
        rem_sh = {rem_q[AccW-3:0], num_q[AccW-1 -: 2]};
        trial  = {1'b0, rem_sh} - {1'b0, quo_q[AccW-3:0], 2'b01};
        num_d  = num_q << 2;
      end else begin
        rem_sh = {rem_q[AccW-2:0], num_q[AccW-1]};
        trial  = {1'b0, rem_sh} - {{(AccW-16){1'b0}}, den_q};
        num_d  = num_q << 1;
      end
      if (!trial[AccW]) begin
        rem_d = trial[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    num_q  <= num_d;
    den_q  <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

endmodule

### hdl/vector_distance_accumulator.sv
// top level: element-pair sequencer, accumulator and result register
// sequencing: euclidean/maximum/manhattan terms go idle, multiply, accumulate; canberra
//   adds a divide on the 24-step shared divider unless the denominator is zero; a last beat
//   adds the result register, and under euclidean the 24-step square root on the same unit
// input: a new beat is taken only in idle, once the previous one is accumulated, so the wait
//   is set by the shared shift-subtract unit and grows while a finished result still waits in the output register
// reset: metric, accumulator and saturation flag clear; no result pending
module vector_distance_accumulator
  import vda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vda_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vda_out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StAcc   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StSqrt  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [1:0]      metric_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [16:0]     ad_q, ad_d;
  logic [16:0]     den_q, den_d;
  logic            last_q, last_d;
  logic [AccW-1:0] term_q, term_d;
  logic            out_valid_q, out_valid_d;
  vda_out_t        out_q, out_d;
  vda_ss_req_t     ss_req;
  vda_ss_rsp_t     ss_rsp;

  logic signed [16:0] diff;
  logic [16:0]     xa, ya;
  logic [AccW:0]   sum;

  vda_shift_sub u_ss (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ss_req),
    .rsp_o  (ss_rsp)
  );

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetricEuclid;
    end else if (cfg_we_i) begin
      metric_q <= cfg_wdata_i;
    end
  end

  // operand difference and magnitudes, accumulator sum
  always_comb begin
    diff = 17'(in_data_i.x_value) - 17'(in_data_i.y_value);
    xa   = in_data_i.x_value[15] ? 17'(-17'(in_data_i.x_value)) : 17'(in_data_i.x_value);
    ya   = in_data_i.y_value[15] ? 17'(-17'(in_data_i.y_value)) : 17'(in_data_i.y_value);
    sum  = {1'b0, acc_q} + {1'b0, term_q};
  end

  assign in_ready_o = (state_q == StIdle);

  // sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    ad_d        = ad_q;
    den_d       = den_q;
    last_d      = last_q;
    term_d      = term_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ss_req      = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          ad_d   = diff[16] ? 17'(-diff) : 17'(diff);
          den_d  = xa + ya;
          last_d = in_data_i.last;
          state_d = StMul;
        end
      end
      StMul: begin
        unique case (metric_q)
          MetricEuclid: begin
            term_d  = AccW'(34'(ad_q) * 34'(ad_q));
            state_d = StAcc;
          end
          MetricCanberra: begin
            if (den_q == '0) begin
              term_d  = '0;
              state_d = StAcc;
            end else begin
              ss_req.start     = 1'b1;
              ss_req.sqrt_mode = 1'b0;
              ss_req.num       = {{(AccW-17){1'b0}}, ad_q};
              ss_req.den       = den_q;
              state_d          = StDiv;
            end
          end
          default: begin
            term_d  = AccW'(ad_q);
            state_d = StAcc;
          end
        endcase
      end
      StDiv: begin
        if (ss_rsp.done) begin
          term_d  = ss_rsp.result;
          state_d = StAcc;
        end
      end
      StAcc: begin
        if (metric_q == MetricMaximum) begin
          if (term_q > acc_q) acc_d = term_q;
        end else if (sum[AccW]) begin
          acc_d = AccMax;
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[AccW-1:0];
        end
        if (!last_q) begin
          state_d = StIdle;
        end else if (metric_q == MetricEuclid) begin
          state_d = StSqrt;
        end else begin
          state_d = StOut;
        end
      end
      StSqrt: begin
        if (!ss_rsp.done && !ss_req.start && term_q != AccMax) begin
          ss_req.start     = 1'b1;
          ss_req.sqrt_mode = 1'b1;
          ss_req.num       = acc_q;
          term_d           = AccMax;
        end else if (ss_rsp.done) begin
          acc_d   = ss_rsp.result;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.distance  = acc_q;
          out_d.saturated = ovf_q;
          acc_d           = '0;
          ovf_d           = 1'b0;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q   <= ad_d;
    den_q  <= den_d;
    last_q <= last_d;
    term_q <= term_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_valid_q) |=> (acc_q == '0 && !ovf_q))
    else $error("accumulator not cleared");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q)) else $error("result changed");

endmodule

### tb/tb_vector_distance_accumulator.sv
// self-checking testbench for the vector distance accumulator
module tb_vector_distance_accumulator;
  import vda_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned RandBeats = 650;
  localparam int unsigned RandPhases = 10;

  typedef struct {
    vda_in_t    beat;
    logic [1:0] metric;
    bit         typed;
    vda_out_t   result;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  logic [1:0] cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  vda_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vda_out_t out_data;

  // predictor state
  logic [1:0]  metric_q;
  logic [63:0] acc_q;
  bit          sat_q;

  vda_out_t    dist_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned vectors_seen;
  int unsigned beats_sent;
  bit          no_idle;
  int unsigned stall_left;

  vector_distance_accumulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor of the square root, one result bit per pass
  function automatic logic [47:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 23; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r[47:0];
  endfunction

  function automatic void add_term(input logic [63:0] term);
    logic [63:0] s;
    s = acc_q + term;
    if (s > {16'd0, AccMax}) begin
      acc_q = {16'd0, AccMax};
      sat_q = 1'b1;
    end else begin
      acc_q = s;
    end
  endfunction

  // fold one accepted beat into the predicted accumulator
  function automatic bit fold_beat(input vda_in_t b, output vda_out_t r);
    longint xs;
    longint ys;
    longint d;
    logic [63:0] ad;
    logic [63:0] den;
    xs = longint'($signed(b.x_value));
    ys = longint'($signed(b.y_value));
    d  = xs - ys;
    ad = (d < 0) ? -d : d;
    case (metric_q)
      MetricEuclid:    add_term(ad * ad);
      MetricMaximum:   if (ad > acc_q) acc_q = ad;
      MetricManhattan: add_term(ad);
      default: begin
        den = ((xs < 0) ? -xs : xs) + ((ys < 0) ? -ys : ys);
        if (den != 0) add_term((ad << 16) / den);
      end
    endcase
    r = '0;
    if (!b.last) return 1'b0;
    r.distance  = (metric_q == MetricEuclid) ? floor_sqrt(acc_q) : acc_q[47:0];
    r.saturated = sat_q;
    acc_q = '0;
    sat_q = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one beat; valid stays high when the next beat follows at once
  task automatic send_beat(input vda_in_t b, input bit typed, input vda_out_t typed_res);
    int unsigned gap;
    vda_out_t    r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    beats_sent++;
    if (fold_beat(b, r)) dist_q.push_back(typed ? typed_res : r);
  endtask

  // metric write once the block has drained
  task automatic write_metric(input logic [1:0] m);
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    metric_q = m;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: stall_left <= $urandom_range(10, 60);
        1, 2, 3: stall_left <= $urandom_range(0, 3);
        default: stall_left <= 0;
      endcase
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result check
  always @(posedge clk_i) begin
    vda_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected result distance=%0d saturated=%0b", $time,
                 out_data.distance, out_data.saturated);
        errors++;
      end else begin
        want = dist_q.pop_front();
        vectors_seen++;
        if (out_data.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   want.distance, out_data.distance);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL vector_distance_accumulator");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    vda_out_t    none;
    vda_in_t     b;
    int unsigned remain;

    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    metric_q  = MetricEuclid;
    acc_q     = '0;
    sat_q     = 1'b0;
    errors    = 0;
    cycles    = 0;
    no_idle   = 1'b0;
    none      = '0;
    vectors_seen = 0;
    beats_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: extremes, every metric, zero denominator, mid-vector change
    rows = '{
      '{'{16'h0000, 16'h0000, 1'b1}, MetricEuclid,    1'b1, '{48'd0, 1'b0}},
      '{'{16'h0300, 16'h0000, 1'b1}, MetricEuclid,    1'b1, '{48'd768, 1'b0}},
      '{'{16'h7fff, 16'h8000, 1'b1}, MetricEuclid,    1'b1, '{48'd65535, 1'b0}},
      '{'{16'h1234, 16'hfa99, 1'b1}, MetricEuclid,    1'b0, '{48'd0, 1'b0}},
      '{'{16'h7fff, 16'h8000, 1'b1}, MetricMaximum,   1'b1, '{48'd65535, 1'b0}},
      '{'{16'h8000, 16'h7fff, 1'b1}, MetricMaximum,   1'b1, '{48'd65535, 1'b0}},
      '{'{16'hffff, 16'h0001, 1'b0}, MetricMaximum,   1'b0, '{48'd0, 1'b0}},
      '{'{16'h7fff, 16'h7fff, 1'b1}, MetricMaximum,   1'b1, '{48'd2, 1'b0}},
      '{'{16'h0100, 16'hff00, 1'b0}, MetricManhattan, 1'b0, '{48'd0, 1'b0}},
      '{'{16'h8000, 16'h8000, 1'b1}, MetricManhattan, 1'b1, '{48'd512, 1'b0}},
      '{'{16'h0000, 16'h0000, 1'b1}, MetricCanberra,  1'b1, '{48'd0, 1'b0}},
      '{'{16'h0100, 16'h0000, 1'b1}, MetricCanberra,  1'b1, '{48'd65536, 1'b0}},
      '{'{16'h8000, 16'h7fff, 1'b1}, MetricCanberra,  1'b1, '{48'd65536, 1'b0}},
      '{'{16'h0005, 16'h0003, 1'b0}, MetricCanberra,  1'b0, '{48'd0, 1'b0}},
      '{'{16'h0001, 16'hfffe, 1'b1}, MetricManhattan, 1'b0, '{48'd0, 1'b0}},
      '{'{16'h0007, 16'hfff0, 1'b0}, MetricManhattan, 1'b0, '{48'd0, 1'b0}},
      '{'{16'h0fff, 16'h0001, 1'b1}, MetricEuclid,    1'b0, '{48'd0, 1'b0}}
    };
    foreach (rows[i]) begin
      if (rows[i].metric != metric_q) write_metric(rows[i].metric);
      send_beat(rows[i].beat, rows[i].typed, rows[i].result);
    end

    // random vectors; phases may end mid-vector so the metric changes under it
    remain = $urandom_range(1, 8);
    for (int unsigned p = 0; p < RandPhases; p++) begin
      write_metric(p == 0 ? 2'd0 : (p == 1 ? 2'd3 : 2'($urandom_range(0, 3))));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < RandBeats / RandPhases; i++) begin
        b.x_value = rand_value();
        b.y_value = rand_value();
        remain--;
        b.last = (remain == 0);
        if (remain == 0) remain = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                              : $urandom_range(1, 8);
        send_beat(b, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d beats over all four metrics, %0d distances checked", beats_sent,
             vectors_seen);
    $display("covered extremes, zero denominators, metric switches and output stalls");
    if (errors == 0) begin
      $display("PASS vector_distance_accumulator");
    end else begin
      $display("FAIL vector_distance_accumulator");
    end
    $finish;
  end

endmodule
